[rtl/top_n_sorted_insertion_top_defines.svh]
// assertion macros used by the checker file
`ifndef TOP_N_SORTED_INSERTION_TOP_DEFINES_SVH
`define TOP_N_SORTED_INSERTION_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TNSI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tnsi assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TNSI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tnsi assertion failed");

`endif

[rtl/tnsi_pkg.sv]
package tnsi_pkg;

  localparam int LIST_DEPTH_DEF  = 40;
  localparam int INDEX_WIDTH_DEF = 20;
  localparam int VALUE_WIDTH_DEF = 48;
  localparam int RANK_WIDTH      = 6;

  typedef struct packed {
    logic insert;
    logic shift;
  } tnsi_ctrl_t;

endpackage

[rtl/tnsi_if.sv]
interface tnsi_in_if #(
  parameter int VALUE_WIDTH = tnsi_pkg::VALUE_WIDTH_DEF,
  parameter int INDEX_WIDTH = tnsi_pkg::INDEX_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [INDEX_WIDTH-1:0] element_index;
  logic                   end_of_vector;

  modport source (output valid, value, element_index, end_of_vector, input ready);
  modport sink   (input valid, value, element_index, end_of_vector, output ready);
endinterface

interface tnsi_out_if #(
  parameter int VALUE_WIDTH = tnsi_pkg::VALUE_WIDTH_DEF,
  parameter int INDEX_WIDTH = tnsi_pkg::INDEX_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [tnsi_pkg::RANK_WIDTH-1:0] rank;
  logic [VALUE_WIDTH-1:0]          kept_value;
  logic [INDEX_WIDTH-1:0]          kept_index;
  logic                            filled;
  logic                            last_of_list;

  modport source (output valid, rank, kept_value, kept_index, filled, last_of_list,
                  input ready);
  modport sink   (input valid, rank, kept_value, kept_index, filled, last_of_list,
                  output ready);
endinterface

[rtl/tnsi_cell.sv]
module tnsi_cell #(
  parameter int VALUE_WIDTH = tnsi_pkg::VALUE_WIDTH_DEF,
  parameter int INDEX_WIDTH = tnsi_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tnsi_pkg::tnsi_ctrl_t   ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [INDEX_WIDTH-1:0] new_index,
  input  logic [VALUE_WIDTH-1:0] up_value,
  input  logic [INDEX_WIDTH-1:0] up_index,
  input  logic                   up_gt,
  input  logic [VALUE_WIDTH-1:0] dn_value,
  input  logic [INDEX_WIDTH-1:0] dn_index,
  output logic [VALUE_WIDTH-1:0] value,
  output logic [INDEX_WIDTH-1:0] index,
  output logic                   gt
);

  // new word beats this entry
  assign gt = (new_value > value);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      index <= '0;
    end else if (ctrl.shift) begin
      value <= dn_value;
      index <= dn_index;
    end else if (ctrl.insert) begin
      priority if (up_gt) begin
        value <= up_value;
        index <= up_index;
      end else if (gt) begin
        value <= new_value;
        index <= new_index;
      end
    end
  end

endmodule

[rtl/tnsi_chain.sv]
module tnsi_chain #(
  parameter int LIST_DEPTH  = tnsi_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = tnsi_pkg::VALUE_WIDTH_DEF,
  parameter int INDEX_WIDTH = tnsi_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tnsi_pkg::tnsi_ctrl_t   ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [INDEX_WIDTH-1:0] new_index,
  output logic [VALUE_WIDTH-1:0] head_value,
  output logic [INDEX_WIDTH-1:0] head_index
);

  logic [VALUE_WIDTH-1:0] vals [LIST_DEPTH];
  logic [INDEX_WIDTH-1:0] idxs [LIST_DEPTH];
  logic                   gts  [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] up_value;
    logic [INDEX_WIDTH-1:0] up_index;
    logic                   up_gt;
    logic [VALUE_WIDTH-1:0] dn_value;
    logic [INDEX_WIDTH-1:0] dn_index;

    if (i == 0) begin : g_head
      assign up_value = '0;
      assign up_index = '0;
      assign up_gt    = 1'b0;
    end else begin : g_up
      assign up_value = vals[i-1];
      assign up_index = idxs[i-1];
      assign up_gt    = gts[i-1];
    end

    // zeros enter at the tail during readout
    if (i == LIST_DEPTH - 1) begin : g_tail
      assign dn_value = '0;
      assign dn_index = '0;
    end else begin : g_dn
      assign dn_value = vals[i+1];
      assign dn_index = idxs[i+1];
    end

    tnsi_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX_WIDTH (INDEX_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_value (new_value),
      .new_index (new_index),
      .up_value  (up_value),
      .up_index  (up_index),
      .up_gt     (up_gt),
      .dn_value  (dn_value),
      .dn_index  (dn_index),
      .value     (vals[i]),
      .index     (idxs[i]),
      .gt        (gts[i])
    );
  end

  assign head_value = vals[0];
  assign head_index = idxs[0];

endmodule

[rtl/top_n_sorted_insertion_top.sv]
// channel  | modport | fields
// item     | sink    | value, element_index, end_of_vector
// result   | source  | rank, kept_value, kept_index, filled, last_of_list
//
// one word per cycle enters while the list is not being read out
// a word marked end_of_vector is inserted, then LIST_DEPTH result words follow,
// one per accepted output cycle, shifted out of the head cell of the chain
// item.ready is low during readout; a stalled result holds in the head cell
// readout empties the list, so it ends cleared
// rst is synchronous and clears the list and the control
module top_n_sorted_insertion_top #(
  parameter int LIST_DEPTH  = tnsi_pkg::LIST_DEPTH_DEF,
  parameter int INDEX_WIDTH = tnsi_pkg::INDEX_WIDTH_DEF,
  parameter int VALUE_WIDTH = tnsi_pkg::VALUE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tnsi_in_if.sink    item,
  tnsi_out_if.source result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                            state;
  logic                            state_next;
  logic [tnsi_pkg::RANK_WIDTH-1:0] rank;
  logic [tnsi_pkg::RANK_WIDTH-1:0] rank_next;
  tnsi_pkg::tnsi_ctrl_t            ctrl;
  logic                            in_acc;
  logic                            out_acc;
  logic                            at_last;
  logic [VALUE_WIDTH-1:0]          head_value;
  logic [INDEX_WIDTH-1:0]          head_index;

  assign item.ready   = (state == ST_IDLE);
  assign result.valid = (state == ST_READ);
  assign in_acc       = item.valid && item.ready;
  assign out_acc      = result.valid && result.ready;
  assign at_last      = (rank == tnsi_pkg::RANK_WIDTH'(LIST_DEPTH - 1));

  always_comb begin
    state_next  = state;
    rank_next   = rank;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.insert = 1'b1;
          if (item.end_of_vector) begin
            state_next = ST_READ;
            rank_next  = '0;
          end
        end
      end
      ST_READ: begin
        if (out_acc) begin
          ctrl.shift = 1'b1;
          rank_next  = rank + 1'b1;
          if (at_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rank  <= '0;
    end else begin
      state <= state_next;
      rank  <= rank_next;
    end
  end

  tnsi_chain #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .new_value  (item.value),
    .new_index  (item.element_index),
    .head_value (head_value),
    .head_index (head_index)
  );

  assign result.rank         = rank;
  assign result.kept_value   = head_value;
  assign result.kept_index   = head_index;
  assign result.filled       = (head_value != '0);
  assign result.last_of_list = at_last;

endmodule

[rtl/tnsi_checker.sv]
`include "top_n_sorted_insertion_top_defines.svh"

module tnsi_checker #(
  parameter int VALUE_WIDTH = tnsi_pkg::VALUE_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tnsi_pkg::RANK_WIDTH-1:0] out_rank,
  input logic [VALUE_WIDTH-1:0]          out_value,
  input logic                            out_last
);

  // stalled result word holds
  `TNSI_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_rank) && $stable(out_value))
  // no word taken during readout
  `TNSI_ASSERT_NOW(a_no_in_during_read, out_valid, !in_ready)
  // readout starts right after the final word of a vector
  `TNSI_ASSERT_NXT(a_read_starts, in_valid && in_ready && in_last,
                   out_valid && (out_rank == '0))
  // readout ends on the final rank
  `TNSI_ASSERT_NXT(a_read_ends, out_valid && out_ready && out_last,
                   !out_valid && in_ready)

endmodule

bind top_n_sorted_insertion_top tnsi_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tnsi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_last   (item.end_of_vector),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_rank  (result.rank),
  .out_value (result.kept_value),
  .out_last  (result.last_of_list)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH = tnsi_pkg::LIST_DEPTH_DEF;
  localparam int VW = tnsi_pkg::VALUE_WIDTH_DEF;
  localparam int IW = tnsi_pkg::INDEX_WIDTH_DEF;
  localparam int RW = tnsi_pkg::RANK_WIDTH;
  localparam int N_ROWS = 17;
  localparam int RANDOM_WORDS = 83;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [VW-1:0] VALUE_MAX = '1;
  localparam logic [IW-1:0] INDEX_MAX = '1;

  typedef struct packed {
    logic [RW-1:0] rank;
    logic [VW-1:0] value;
    logic [IW-1:0] index;
    logic filled;
    logic last;
  } ranked_entry_t;

  // typed rows carry the head entry of a list holding at most one element
  typedef struct packed {
    logic [VW-1:0] value;
    logic [IW-1:0] index;
    logic eov;
    logic typed;
    logic [VW-1:0] head_value;
    logic [IW-1:0] head_index;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst;

  tnsi_in_if item_ch ();
  tnsi_out_if result_ch ();

  top_n_sorted_insertion_top dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  logic [VW-1:0] kept_values [DEPTH];
  logic [IW-1:0] kept_indices [DEPTH];
  ranked_entry_t expected_ranks [$];
  vector_row_t directed_rows [N_ROWS];

  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit hold_request = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int phase_cnt = 0;
  int stall_mode = 0;
  bit timed_out = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void rank_element(input logic [VW-1:0] v, input logic [IW-1:0] ix,
                                       input logic eov, input logic typed,
                                       input logic [VW-1:0] hv, input logic [IW-1:0] hix);
    int pos;
    int k;
    bit placed;
    ranked_entry_t e;
    placed = 0;
    for (pos = 0; pos < DEPTH; pos++) begin
      if (!placed && v > kept_values[pos]) begin
        for (k = DEPTH - 1; k > pos; k--) begin
          kept_values[k] = kept_values[k-1];
          kept_indices[k] = kept_indices[k-1];
        end
        kept_values[pos] = v;
        kept_indices[pos] = ix;
        placed = 1;
      end
    end
    if (eov) begin
      for (k = 0; k < DEPTH; k++) begin
        e.rank = RW'(k);
        if (typed) begin
          e.value = (k == 0) ? hv : '0;
          e.index = (k == 0) ? hix : '0;
        end else begin
          e.value = kept_values[k];
          e.index = kept_indices[k];
        end
        e.filled = (e.value != '0);
        e.last = (k == DEPTH - 1);
        expected_ranks = {expected_ranks, e};
      end
      for (k = 0; k < DEPTH; k++) begin
        kept_values[k] = '0;
        kept_indices[k] = '0;
      end
    end
  endfunction

  function automatic logic [VW-1:0] pick_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return VW'($urandom_range(1, 8));
      4: return VALUE_MAX;
      5: return VW'(64'd1 << $urandom_range(0, VW - 1));
      default: return raw[VW-1:0];
    endcase
  endfunction

  function automatic logic [IW-1:0] pick_index();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return INDEX_MAX;
      default: return raw[IW-1:0];
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input ranked_entry_t want,
                                        input ranked_entry_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected rank %0d value %h index %h filled %b last %b", $realtime,
               what, want.rank, want.value, want.index, want.filled, want.last);
      $display("%0t %s:   actual rank %0d value %h index %h filled %b last %b", $realtime,
               what, got.rank, got.value, got.index, got.filled, got.last);
    end
  endfunction

  task automatic offer_word(input logic [VW-1:0] v, input logic [IW-1:0] ix, input logic eov,
                            input logic typed, input logic [VW-1:0] hv,
                            input logic [IW-1:0] hix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.element_index <= ix;
    item_ch.end_of_vector <= eov;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    rank_element(v, ix, eov, typed, hv, hix);
  endtask

  // receiver: one long hold on the first readout after the directed rows are sent, else a rotating pattern
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done && result_ch.valid) begin
      result_ch.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      phase_cnt <= phase_cnt + 1;
      if (phase_cnt % 32 == 0) begin
        stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'($urandom_range(0, 1));
        2: result_ch.ready <= ($urandom_range(0, 3) == 0);
        default: result_ch.ready <= (phase_cnt % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    ranked_entry_t got;
    ranked_entry_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.rank = result_ch.rank;
      got.value = result_ch.kept_value;
      got.index = result_ch.kept_index;
      got.filled = result_ch.filled;
      got.last = result_ch.last_of_list;
      if (expected_ranks.size() == 0) begin
        flag_mismatch("unexpected word", '0, got);
      end else begin
        want = expected_ranks.pop_front();
        if (got.rank !== want.rank || got.value !== want.value || got.index !== want.index ||
            got.filled !== want.filled || got.last !== want.last) begin
          flag_mismatch("result word", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    int n;
    int len;
    int sent;
    bit first;

    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.value = '0;
    item_ch.element_index = '0;
    item_ch.end_of_vector = 1'b0;
    for (r = 0; r < DEPTH; r++) begin
      kept_values[r] = '0;
      kept_indices[r] = '0;
    end

    directed_rows = '{
      '{'0, 20'h00005, 1'b1, 1'b1, '0, '0},
      '{VALUE_MAX, INDEX_MAX, 1'b1, 1'b1, VALUE_MAX, INDEX_MAX},
      '{48'd1, '0, 1'b1, 1'b1, 48'd1, '0},
      '{48'd7, 20'd1, 1'b0, 1'b0, '0, '0},
      '{48'd7, 20'd2, 1'b0, 1'b0, '0, '0},
      '{48'd9, 20'd3, 1'b0, 1'b0, '0, '0},
      '{'0, 20'd4, 1'b0, 1'b0, '0, '0},
      '{48'd3, 20'd5, 1'b0, 1'b0, '0, '0},
      '{48'd7, 20'd6, 1'b0, 1'b0, '0, '0},
      '{VALUE_MAX, 20'd7, 1'b0, 1'b0, '0, '0},
      '{48'd2, 20'd8, 1'b1, 1'b0, '0, '0},
      '{48'hAAAA_AAAA_AAAA, 20'h55555, 1'b0, 1'b0, '0, '0},
      '{48'h5555_5555_5555, 20'hAAAAA, 1'b0, 1'b0, '0, '0},
      '{48'h8000_0000_0000, 20'h80000, 1'b0, 1'b0, '0, '0},
      '{48'h7FFF_FFFF_FFFF, 20'h7FFFF, 1'b1, 1'b0, '0, '0},
      '{48'd5, INDEX_MAX, 1'b1, 1'b1, 48'd5, INDEX_MAX},
      '{'0, INDEX_MAX, 1'b1, 1'b1, '0, '0}
    };

    fork
      begin
        repeat (6) @(posedge clk);
        rst <= 1'b0;
        @(posedge clk);

        for (r = 0; r < N_ROWS; r++) begin
          offer_word(directed_rows[r].value, directed_rows[r].index, directed_rows[r].eov,
                     directed_rows[r].typed, directed_rows[r].head_value,
                     directed_rows[r].head_index);
        end

        hold_request = 1'b1;
        sent = 0;
        first = 1;
        while (sent < RANDOM_WORDS) begin
          if (first) begin
            len = $urandom_range(41, 52);
          end else if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(41, 50);
          end else begin
            len = $urandom_range(1, 10);
          end
          if (len > RANDOM_WORDS - sent) begin
            len = RANDOM_WORDS - sent;
          end
          first = 0;
          for (n = 0; n < len; n++) begin
            offer_word(pick_value(), pick_index(), (n == len - 1), 1'b0, '0, '0);
            sent++;
          end
        end
        item_ch.valid <= 1'b0;

        while (expected_ranks.size() != 0) @(posedge clk);
        repeat (DEPTH + 20) @(posedge clk);
      end
      begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[top_n_sorted_insertion_top.f]
+incdir+rtl
rtl/tnsi_pkg.sv
rtl/tnsi_if.sv
rtl/tnsi_cell.sv
rtl/tnsi_chain.sv
rtl/top_n_sorted_insertion_top.sv
rtl/tnsi_checker.sv
verif/tb_top.sv
